@@ sv/assert_macros.svh @@
// Assertion helpers for the tree extend unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, ante, cons)
`define ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ sv/rrt_pkg.sv @@
package rrt_pkg;

	localparam int CW   = 16;          // coordinate width
	localparam int RW   = 15;          // radius / step width
	localparam int IW   = 10;          // index field width
	localparam int OCW  = 11;          // obstacle count register width
	localparam int DW   = 2 * (CW + 1); // squared distance width
	localparam int MW   = 36;          // serial multiplier operand width
	localparam int MCH  = 12;          // multiplier digit width
	localparam int MNCH = 3;           // digits per operand
	localparam int PW   = 2 * MW;

	typedef enum logic [1:0] {
		OP_RESTART  = 2'd0,
		OP_OBSTACLE = 2'd1,
		OP_EXTEND   = 2'd2,
		OP_READ     = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_DONE     = 3'd0,
		ST_ADDED    = 3'd1,
		ST_COLLIDED = 3'd2,
		ST_FULL     = 3'd3,
		ST_READ     = 3'd4,
		ST_INVALID  = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		SM_NEAR = 2'd0,
		SM_OBS  = 2'd1,
		SM_GOAL = 2'd2
	} scan_mode_t;

	typedef enum logic [2:0] {
		CFG_START_X   = 3'd0,
		CFG_START_Y   = 3'd1,
		CFG_GOAL_X    = 3'd2,
		CFG_GOAL_Y    = 3'd3,
		CFG_STEP      = 3'd4,
		CFG_OBS_COUNT = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic       capture;
		logic       restart;
		logic       obs_wr;
		logic       rd_node;
		logic       scan_start;
		scan_mode_t mode;
		logic       step_start;
		logic       newpt;
		logic       append;
		logic       out_load;
		status_t    kind;
	} dp_cmd_t;

	typedef struct packed {
		op_t  op;
		logic full;
		logic obs_idx_ok;
		logic node_idx_ok;
		logic scan_done;
		logic step_done;
		logic hit;
	} dp_stat_t;

	typedef struct packed {
		status_t        status;
		logic [IW-1:0]  node_index;
		logic [CW-1:0]  node_x;
		logic [CW-1:0]  node_y;
		logic [IW-1:0]  parent_index;
		logic           has_parent;
		logic           goal_reached;
	} res_t;

endpackage

@@ sv/rrt_mul.sv @@
module rrt_mul (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [rrt_pkg::MW-1:0]  a,
	input  logic [rrt_pkg::MW-1:0]  b,
	output logic [rrt_pkg::PW-1:0]  p,
	output logic                    done
);
	import rrt_pkg::*;

	localparam int KW = $clog2(MNCH + 1);

	logic [MW-1:0]     a_q, b_q;
	logic [PW-1:0]     acc_q;
	logic [KW-1:0]     k_q;
	logic              busy_q, done_q;
	logic [MW+MCH-1:0] pp;

	// top digit first: acc = acc * 2^MCH + a * digit
	assign pp = a_q * b_q[MW-1 -: MCH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			k_q    <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			k_q    <= '0;
		end else if (busy_q) begin
			k_q <= k_q + KW'(1);
			if (k_q == KW'(MNCH - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= (acc_q << MCH) + PW'(pp);
			b_q   <= b_q << MCH;
		end
	end

	assign p    = acc_q;
	assign done = done_q;

endmodule

@@ sv/rrt_step.sv @@
module rrt_step (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [rrt_pkg::RW-1:0] s,
	input  logic [rrt_pkg::CW:0]   a,
	input  logic [rrt_pkg::DW-1:0] d2,
	output logic [rrt_pkg::RW-1:0] q,
	output logic                   done
);
	import rrt_pkg::*;

	// q = round(s*a/sqrt(d2)): largest q with (2q-1)^2*d2 <= (2sa)^2
	localparam int NW = RW + CW + 2;
	localparam int TW = RW + 1;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_N    = 7'b0000010,
		S_NN   = 7'b0000100,
		S_NNW  = 7'b0001000,
		S_LOOP = 7'b0010000,
		S_TMUL = 7'b0100000,
		S_TW   = 7'b1000000
	} step_state_t;

	step_state_t     state_q;
	logic            done_q;
	logic [RW-1:0]   s_q, lo_q, hi_q, mid_q;
	logic [CW:0]     a_q;
	logic [DW-1:0]   d2_q;
	logic [NW-1:0]   n_q;
	logic [2*TW-1:0] tt_q;
	logic [PW-1:0]   r_q;
	logic [NW-2:0]   sa;
	logic [RW:0]     msum;
	logic [RW-1:0]   mid;
	logic [TW-1:0]   t;
	logic [2*TW-1:0] tt;
	logic            mul_start, mul_done;
	logic [MW-1:0]   mul_a, mul_b;
	logic [PW-1:0]   mul_p;

	assign sa   = s_q * a_q;
	assign msum = {1'b0, lo_q} + {1'b0, hi_q} + (RW+1)'(1);
	assign mid  = msum[RW:1];
	assign t    = {mid, 1'b0} - TW'(1);
	assign tt   = t * t;

	assign mul_start = (state_q == S_NN) || (state_q == S_TMUL);
	assign mul_a     = (state_q == S_NN) ? MW'(n_q) : MW'(tt_q);
	assign mul_b     = (state_q == S_NN) ? MW'(n_q) : MW'(d2_q);

	rrt_mul u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.a     (mul_a),
		.b     (mul_b),
		.p     (mul_p),
		.done  (mul_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (start) begin
					state_q <= S_N;
					done_q  <= 1'b0;
				end
				S_N:    state_q <= S_NN;
				S_NN:   state_q <= S_NNW;
				S_NNW:  if (mul_done) state_q <= S_LOOP;
				S_LOOP: begin
					if (lo_q < hi_q) begin
						state_q <= S_TMUL;
					end else begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				S_TMUL: state_q <= S_TW;
				S_TW:   if (mul_done) state_q <= S_LOOP;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			s_q  <= s;
			a_q  <= a;
			d2_q <= d2;
		end
		if (state_q == S_N) n_q <= {sa, 1'b0};
		if (state_q == S_NNW && mul_done) begin
			r_q  <= mul_p;
			lo_q <= '0;
			hi_q <= s_q;
		end
		if (state_q == S_LOOP) begin
			mid_q <= mid;
			tt_q  <= tt;
		end
		if (state_q == S_TW && mul_done) begin
			if (mul_p <= r_q) lo_q <= mid_q;
			else              hi_q <= mid_q - RW'(1);
		end
	end

	assign q    = lo_q;
	assign done = done_q;

endmodule

@@ sv/rrt_dpath.sv @@
module rrt_dpath #(
	parameter int MAX_NODES     = 1024,
	parameter int MAX_OBSTACLES = 1024,
	parameter int FRAC_BITS     = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [2:0]              cfg_index,
	input  logic [rrt_pkg::CW-1:0]  cfg_data,
	input  rrt_pkg::op_t            in_op,
	input  logic [rrt_pkg::CW-1:0]  in_x,
	input  logic [rrt_pkg::CW-1:0]  in_y,
	input  logic [rrt_pkg::RW-1:0]  in_r,
	input  logic [rrt_pkg::IW-1:0]  in_idx,
	input  rrt_pkg::dp_cmd_t        cmd,
	output rrt_pkg::dp_stat_t       stat,
	output rrt_pkg::res_t           res
);
	import rrt_pkg::*;

	localparam int TAW  = $clog2(MAX_NODES);
	localparam int OAW  = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
	localparam int SZW  = $clog2(MAX_NODES + 1);
	localparam int MAXN = (MAX_NODES > MAX_OBSTACLES) ? MAX_NODES : MAX_OBSTACLES;
	localparam int CNTW = $clog2(MAXN + 1);
	localparam int XW   = 17;
	localparam logic [CW-1:0] START_RST = CW'(5 << FRAC_BITS);
	localparam logic [CW-1:0] GOAL_RST  = CW'(9 << FRAC_BITS);
	localparam logic [RW-1:0] STEP_RST  = RW'(((1 << FRAC_BITS) + 5) / 10);

	// configuration
	logic [CW-1:0]  start_x_q, start_y_q, goal_x_q, goal_y_q;
	logic [RW-1:0]  step_q;
	logic [OCW-1:0] ocount_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q <= START_RST;
			start_y_q <= START_RST;
			goal_x_q  <= GOAL_RST;
			goal_y_q  <= GOAL_RST;
			step_q    <= STEP_RST;
			ocount_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_START_X:   start_x_q <= cfg_data;
				CFG_START_Y:   start_y_q <= cfg_data;
				CFG_GOAL_X:    goal_x_q  <= cfg_data;
				CFG_GOAL_Y:    goal_y_q  <= cfg_data;
				CFG_STEP:      step_q    <= cfg_data[RW-1:0];
				CFG_OBS_COUNT: ocount_q  <= cfg_data[OCW-1:0];
				default: ;
			endcase
		end
	end

	// captured command beat
	op_t           op_q;
	logic [CW-1:0] px_q, py_q;
	logic [RW-1:0] pr_q;
	logic [IW-1:0] idx_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= in_op;
			px_q  <= in_x;
			py_q  <= in_y;
			pr_q  <= in_r;
			idx_q <= in_idx;
		end
	end

	// tree size and root; node 0 lives in registers
	logic [SZW-1:0] size_q;
	logic [CW-1:0]  root_x_q, root_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q   <= SZW'(1);
			root_x_q <= START_RST;
			root_y_q <= START_RST;
		end else if (cmd.restart) begin
			size_q   <= SZW'(1);
			root_x_q <= start_x_q;
			root_y_q <= start_y_q;
		end else if (cmd.append) begin
			size_q <= size_q + SZW'(1);
		end
	end

	// scan engine
	logic [CNTW-1:0] cnt_q, lim_q, obs_lim, lim_d;
	logic            run_q, first_q, hit_q;
	scan_mode_t      mode_q;
	logic            issue, scan_done;

	// nearest node so far
	logic [DW-1:0]  bd_q;
	logic [TAW-1:0] best_q;
	logic [CW-1:0]  bx_q, by_q;

	assign obs_lim = (17'(ocount_q) < 17'(MAX_OBSTACLES)) ? CNTW'(ocount_q)
	                                                     : CNTW'(MAX_OBSTACLES);
	always_comb begin
		case (cmd.mode)
			SM_NEAR: lim_d = CNTW'(size_q);
			SM_OBS:  lim_d = obs_lim;
			default: lim_d = CNTW'(1);
		endcase
	end

	assign issue = run_q && (cnt_q < lim_q);

	// memories
	logic [CW-1:0]  tx_mem [MAX_NODES];
	logic [CW-1:0]  ty_mem [MAX_NODES];
	logic [TAW-1:0] tp_mem [MAX_NODES];
	logic [CW-1:0]  cx_mem [MAX_OBSTACLES];
	logic [CW-1:0]  cy_mem [MAX_OBSTACLES];
	logic [RW-1:0]  cr_mem [MAX_OBSTACLES];

	logic           t_ren, c_ren;
	logic [TAW-1:0] t_raddr;
	logic [OAW-1:0] c_raddr;
	logic [CW-1:0]  tx_s1, ty_s1, cx_s1, cy_s1, nx_q, ny_q;
	logic [TAW-1:0] tp_s1;
	logic [RW-1:0]  cr_s1;
	logic           root_s1;
	logic [CW-1:0]  trx, try_;

	assign t_ren   = cmd.rd_node || (issue && mode_q == SM_NEAR);
	assign t_raddr = cmd.rd_node ? TAW'(idx_q) : cnt_q[TAW-1:0];
	assign c_ren   = issue && mode_q == SM_OBS;
	assign c_raddr = cnt_q[OAW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.append) begin
			tx_mem[size_q[TAW-1:0]] <= nx_q;
			ty_mem[size_q[TAW-1:0]] <= ny_q;
			tp_mem[size_q[TAW-1:0]] <= best_q;
		end
		if (t_ren) begin
			tx_s1   <= tx_mem[t_raddr];
			ty_s1   <= ty_mem[t_raddr];
			tp_s1   <= tp_mem[t_raddr];
			root_s1 <= (t_raddr == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.obs_wr) begin
			cx_mem[OAW'(idx_q)] <= px_q;
			cy_mem[OAW'(idx_q)] <= py_q;
			cr_mem[OAW'(idx_q)] <= pr_q;
		end
		if (c_ren) begin
			cx_s1 <= cx_mem[c_raddr];
			cy_s1 <= cy_mem[c_raddr];
			cr_s1 <= cr_mem[c_raddr];
		end
	end

	assign trx  = root_s1 ? root_x_q : tx_s1;
	assign try_ = root_s1 ? root_y_q : ty_s1;

	// distance pipeline
	logic                  v_s1, v_s2, v_s3;
	logic [TAW-1:0]        idx_s1, idx_s2, idx_s3;
	logic [CW-1:0]         a_x, a_y, b_x, b_y;
	logic [RW-1:0]         r_sel, r_s2;
	logic signed [XW-1:0]  dx_s2, dy_s2;
	logic [CW-1:0]         ax_s2, ay_s2, ax_s3, ay_s3;
	logic signed [DW-1:0]  sqx, sqy;
	logic [DW-1:0]         dx2_s3, dy2_s3, dsum;
	logic [2*RW-1:0]       r2, r2_s3;

	always_comb begin
		case (mode_q)
			SM_NEAR: begin
				a_x = trx;      a_y = try_;
				b_x = px_q;     b_y = py_q;
				r_sel = '0;
			end
			SM_OBS: begin
				a_x = cx_s1;    a_y = cy_s1;
				b_x = nx_q;     b_y = ny_q;
				r_sel = cr_s1;
			end
			default: begin
				a_x = goal_x_q; a_y = goal_y_q;
				b_x = nx_q;     b_y = ny_q;
				r_sel = step_q;
			end
		endcase
	end

	assign sqx  = dx_s2 * dx_s2;
	assign sqy  = dy_s2 * dy_s2;
	assign r2   = r_s2 * r_s2;
	assign dsum = dx2_s3 + dy2_s3;

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[TAW-1:0];
		idx_s2 <= idx_s1;
		idx_s3 <= idx_s2;
		dx_s2  <= $signed({a_x[CW-1], a_x}) - $signed({b_x[CW-1], b_x});
		dy_s2  <= $signed({a_y[CW-1], a_y}) - $signed({b_y[CW-1], b_y});
		ax_s2  <= a_x;
		ay_s2  <= a_y;
		r_s2   <= r_sel;
		dx2_s3 <= sqx;
		dy2_s3 <= sqy;
		r2_s3  <= r2;
		ax_s3  <= ax_s2;
		ay_s3  <= ay_s2;
	end

	assign scan_done = run_q && !issue && !v_s1 && !v_s2 && !v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			cnt_q   <= '0;
			lim_q   <= '0;
			mode_q  <= SM_NEAR;
			first_q <= 1'b0;
			hit_q   <= 1'b0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (cmd.scan_start) begin
				run_q   <= 1'b1;
				cnt_q   <= '0;
				lim_q   <= lim_d;
				mode_q  <= cmd.mode;
				first_q <= 1'b1;
				hit_q   <= 1'b0;
			end else begin
				if (issue) cnt_q <= cnt_q + CNTW'(1);
				if (scan_done) run_q <= 1'b0;
				if (v_s3) begin
					if (mode_q == SM_NEAR) first_q <= 1'b0;
					else if (dsum <= DW'(r2_s3)) hit_q <= 1'b1;
				end
			end
		end
	end

	// nearest so far; strict compare keeps the lowest index on ties
	always_ff @(posedge clk) begin
		if (v_s3 && mode_q == SM_NEAR && (first_q || dsum < bd_q)) begin
			bd_q   <= dsum;
			best_q <= idx_s3;
			bx_q   <= ax_s3;
			by_q   <= ay_s3;
		end
	end

	// step toward the sample
	logic signed [XW-1:0] ddx, ddy, offx, offy, sumx, sumy;
	logic [XW-1:0]        adx, ady;
	logic [RW-1:0]        qx, qy, magx, magy;
	logic                 dnx, dny, bd_zero;
	logic [SZW-1:0]       added_q;

	assign ddx     = $signed({px_q[CW-1], px_q}) - $signed({bx_q[CW-1], bx_q});
	assign ddy     = $signed({py_q[CW-1], py_q}) - $signed({by_q[CW-1], by_q});
	assign adx     = ddx[XW-1] ? XW'(-ddx) : XW'(ddx);
	assign ady     = ddy[XW-1] ? XW'(-ddy) : XW'(ddy);
	assign bd_zero = (bd_q == '0);

	rrt_step u_step_x (
		.clk(clk), .arst_n(arst_n), .start(cmd.step_start),
		.s(step_q), .a(adx), .d2(bd_q), .q(qx), .done(dnx)
	);
	rrt_step u_step_y (
		.clk(clk), .arst_n(arst_n), .start(cmd.step_start),
		.s(step_q), .a(ady), .d2(bd_q), .q(qy), .done(dny)
	);

	// sample on the node itself: step along +x
	assign magx = bd_zero ? step_q : qx;
	assign magy = bd_zero ? '0 : qy;
	assign offx = (!bd_zero && ddx[XW-1]) ? -$signed({2'b00, magx}) : $signed({2'b00, magx});
	assign offy = (!bd_zero && ddy[XW-1]) ? -$signed({2'b00, magy}) : $signed({2'b00, magy});
	assign sumx = $signed({bx_q[CW-1], bx_q}) + offx;
	assign sumy = $signed({by_q[CW-1], by_q}) + offy;

	function automatic logic [CW-1:0] sat16(input logic signed [XW-1:0] v);
		if (v > $signed(XW'(32767)))       sat16 = 16'h7FFF;
		else if (v < -$signed(XW'(32768))) sat16 = 16'h8000;
		else                               sat16 = v[CW-1:0];
	endfunction

	always_ff @(posedge clk) begin
		if (cmd.newpt) begin
			nx_q <= sat16(sumx);
			ny_q <= sat16(sumy);
		end
		if (cmd.append) added_q <= size_q;
	end

	// status
	assign stat.op          = op_q;
	assign stat.full        = (size_q == SZW'(MAX_NODES));
	assign stat.obs_idx_ok  = (17'(idx_q) < 17'(MAX_OBSTACLES));
	assign stat.node_idx_ok = (17'(idx_q) < 17'(size_q));
	assign stat.scan_done   = scan_done;
	assign stat.step_done   = dnx && dny;
	assign stat.hit         = hit_q;

	// result
	always_comb begin
		res              = '0;
		res.status       = cmd.kind;
		case (cmd.kind)
			ST_READ: begin
				res.node_index   = idx_q;
				res.node_x       = trx;
				res.node_y       = try_;
				res.parent_index = (idx_q != '0) ? IW'(tp_s1) : '0;
				res.has_parent   = (idx_q != '0);
			end
			ST_COLLIDED: begin
				res.node_x       = nx_q;
				res.node_y       = ny_q;
				res.parent_index = IW'(best_q);
				res.has_parent   = 1'b1;
			end
			ST_ADDED: begin
				res.node_index   = IW'(added_q);
				res.node_x       = nx_q;
				res.node_y       = ny_q;
				res.parent_index = IW'(best_q);
				res.has_parent   = 1'b1;
				res.goal_reached = hit_q;
			end
			default: ;
		endcase
	end

endmodule

@@ sv/rrt_ctrl.sv @@
module rrt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               out_free,
	input  rrt_pkg::dp_stat_t  stat,
	output rrt_pkg::dp_cmd_t   cmd
);
	import rrt_pkg::*;

	typedef enum logic [8:0] {
		C_IDLE     = 9'b000000001,
		C_DISPATCH = 9'b000000010,
		C_READ     = 9'b000000100,
		C_NSCAN    = 9'b000001000,
		C_STEP     = 9'b000010000,
		C_NEWPT    = 9'b000100000,
		C_OSCAN    = 9'b001000000,
		C_GSCAN    = 9'b010000000,
		C_OUT      = 9'b100000000
	} ctrl_state_t;

	ctrl_state_t state_q, state_d;
	status_t     kind_q, kind_d;

	always_comb begin
		cmd      = '0;
		cmd.mode = SM_NEAR;
		state_d  = state_q;
		kind_d   = kind_q;
		in_ready = 1'b0;
		case (state_q)
			C_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = C_DISPATCH;
				end
			end
			C_DISPATCH: begin
				state_d = C_OUT;
				kind_d  = ST_DONE;
				case (stat.op)
					OP_RESTART: cmd.restart = 1'b1;
					OP_OBSTACLE: begin
						if (stat.obs_idx_ok) cmd.obs_wr = 1'b1;
						else                 kind_d     = ST_INVALID;
					end
					OP_READ: begin
						if (stat.node_idx_ok) begin
							cmd.rd_node = 1'b1;
							kind_d      = ST_READ;
							state_d     = C_READ;
						end else begin
							kind_d = ST_INVALID;
						end
					end
					OP_EXTEND: begin
						if (stat.full) begin
							kind_d = ST_FULL;
						end else begin
							cmd.scan_start = 1'b1;
							cmd.mode       = SM_NEAR;
							state_d        = C_NSCAN;
						end
					end
					default: ;
				endcase
			end
			C_READ: state_d = C_OUT;
			C_NSCAN: if (stat.scan_done) begin
				cmd.step_start = 1'b1;
				state_d        = C_STEP;
			end
			C_STEP: if (stat.step_done) begin
				cmd.newpt = 1'b1;
				state_d   = C_NEWPT;
			end
			C_NEWPT: begin
				cmd.scan_start = 1'b1;
				cmd.mode       = SM_OBS;
				state_d        = C_OSCAN;
			end
			C_OSCAN: if (stat.scan_done) begin
				if (stat.hit) begin
					kind_d  = ST_COLLIDED;
					state_d = C_OUT;
				end else begin
					cmd.append     = 1'b1;
					cmd.scan_start = 1'b1;
					cmd.mode       = SM_GOAL;
					state_d        = C_GSCAN;
				end
			end
			C_GSCAN: if (stat.scan_done) begin
				kind_d  = ST_ADDED;
				state_d = C_OUT;
			end
			C_OUT: if (out_free) begin
				cmd.out_load = 1'b1;
				state_d      = C_IDLE;
			end
			default: state_d = C_IDLE;
		endcase
		cmd.kind = kind_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			kind_q  <= ST_DONE;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
		end
	end

endmodule

@@ sv/rrt_tree_extend_unit.sv @@
// Tree extend unit: grows a rapidly-exploring random tree in signed Q7.8.
// Slave stream (s_*): one beat per command. s_tuser carries the command
// (restart, add obstacle, extend, read node); s_tdata the point, radius, index.
// Master stream (m_*): exactly one result beat per command; m_tuser is the
// status code, m_tdata the node fields.
// Config channel (cfg_*): write a register by index, always ready; write only
// while no command is in flight.
// Extend runs a one-node-per-cycle nearest scan over the tree memory, then two
// step units side by side (a bisection search of at most 15 steps, each step
// around a serial multiplier), then a one-circle-per-cycle obstacle scan and
// a one-beat goal check.
// One command is processed at a time; a new beat is taken as soon as the
// previous result sits in the output register, even while it is stalled.
// A stalled master side holds the result and blocks only the next result.
// Reset: registers take their defaults, the tree holds only the root at start;
// obstacle and node memories hold garbage until written (no clearing pass).
module rrt_tree_extend_unit #(
	parameter int MAX_NODES     = 1024,
	parameter int MAX_OBSTACLES = 1024,
	parameter int FRAC_BITS     = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [15:0] pos_x, [31:16] pos_y, [46:32] radius, [56:47] index, rest zero
	input  logic [63:0] s_tdata,
	// [1:0] command
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [9:0] node_index, [25:10] node_x, [41:26] node_y, [51:42] parent_index,
	// [52] has_parent, [53] goal_reached, rest zero
	output logic [55:0] m_tdata,
	// [2:0] status
	output logic [2:0]  m_tuser,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import rrt_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;
	res_t     res, res_q;
	logic     m_tvalid_q, out_free;

	assign cfg_ready = 1'b1;
	assign out_free  = !m_tvalid_q || m_tready;

	rrt_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.out_free(out_free),
		.stat    (stat),
		.cmd     (cmd)
	);

	rrt_dpath #(
		.MAX_NODES    (MAX_NODES),
		.MAX_OBSTACLES(MAX_OBSTACLES),
		.FRAC_BITS    (FRAC_BITS)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_op    (op_t'(s_tuser)),
		.in_x     (s_tdata[15:0]),
		.in_y     (s_tdata[31:16]),
		.in_r     (s_tdata[46:32]),
		.in_idx   (s_tdata[56:47]),
		.cmd      (cmd),
		.stat     (stat),
		.res      (res)
	);

	// output register: holds a finished beat while the datapath moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) res_q <= res;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = res_q.status;
	assign m_tdata  = {2'b00, res_q.goal_reached, res_q.has_parent, res_q.parent_index,
	                   res_q.node_y, res_q.node_x, res_q.node_index};

`include "assert_macros.svh"

	// one command in flight: an accepted beat closes the input side
	`ASSERT_NXT(a_one_cmd, s_tvalid && s_tready, !s_tready)
	// a result is never loaded over one still waiting
	`ASSERT_IMP(a_no_overwrite, cmd.out_load, out_free)
	// goal flag only rides on an added node
	`ASSERT_IMP(a_goal_added, m_tvalid && m_tdata[53], m_tuser == ST_ADDED)
	// added nodes always carry a parent
	`ASSERT_IMP(a_added_parent, m_tvalid && m_tuser == ST_ADDED, m_tdata[52])

endmodule

@@ dv/rrt_tree_extend_unit_tb.sv @@
module rrt_tree_extend_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rrt_pkg::*;

	localparam int NODE_CAP = 1024;
	localparam int CIRCLE_CAP = 1024;
	localparam int CIRCLE_LIVE = 32;

	// Expected-result store plus a private copy of the tree, the circles and the
	// registers. note_cmd works out the result of one accepted command beat.
	class tree_scoreboard;
		logic signed [15:0] start_x, start_y, goal_x, goal_y;
		logic [14:0] step_len;
		logic [10:0] obs_count;
		logic signed [15:0] node_x[NODE_CAP];
		logic signed [15:0] node_y[NODE_CAP];
		logic [9:0] node_par[NODE_CAP];
		int node_count;
		logic signed [15:0] circ_x[CIRCLE_CAP];
		logic signed [15:0] circ_y[CIRCLE_CAP];
		logic [14:0] circ_r[CIRCLE_CAP];
		res_t pending_q[$];
		int errors;

		function new();
			start_x = 16'sd1280;
			start_y = 16'sd1280;
			goal_x = 16'sd2304;
			goal_y = 16'sd2304;
			step_len = 15'd26;
			obs_count = '0;
			errors = 0;
			regrow();
		endfunction

		function void regrow();
			node_x[0] = start_x;
			node_y[0] = start_y;
			node_par[0] = '0;
			node_count = 1;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [15:0] v);
			case (idx)
				CFG_START_X: start_x = v;
				CFG_START_Y: start_y = v;
				CFG_GOAL_X: goal_x = v;
				CFG_GOAL_Y: goal_y = v;
				CFG_STEP: step_len = v[14:0];
				CFG_OBS_COUNT: obs_count = v[10:0];
				default: ;
			endcase
		endfunction

		static function longint unsigned dist_sq(int ax, int ay, int bx, int by);
			longint dx, dy;
			dx = longint'(ax) - bx;
			dy = longint'(ay) - by;
			return longint'(dx * dx + dy * dy);
		endfunction

		static function int clamp16(int v);
			if (v > 32767) return 32767;
			if (v < -32768) return -32768;
			return v;
		endfunction

		// round(s*|d|/sqrt(d2)), ties away from zero, done exactly by bisection:
		// largest m with (2m-1)^2 * d2 <= 4 s^2 d^2
		static function int step_share(int s, longint unsigned mag, longint unsigned d2);
			logic [127:0] rhs, lhs, t;
			int lo, hi, mid;
			rhs = 128'(4) * 128'(s) * 128'(s) * 128'(mag) * 128'(mag);
			lo = 0;
			hi = s;
			while (lo < hi) begin
				mid = (lo + hi + 1) / 2;
				t = 128'(2 * mid - 1);
				lhs = t * t * 128'(d2);
				if (lhs <= rhs) lo = mid;
				else hi = mid - 1;
			end
			return lo;
		endfunction

		function void note_cmd(op_t op, logic signed [15:0] px, logic signed [15:0] py,
				logic [14:0] rad, logic [9:0] idx);
			res_t r;
			int best, nx, ny, dx, dy, ox, oy, s, nchk;
			longint unsigned bd, d;
			bit hit;
			r = '0;
			r.status = ST_DONE;
			case (op)
				OP_RESTART: regrow();
				OP_OBSTACLE: begin
					// index is 10 bits, so every slot is in range here
					circ_x[idx] = px;
					circ_y[idx] = py;
					circ_r[idx] = rad;
				end
				OP_EXTEND: begin
					if (node_count >= NODE_CAP) begin
						r.status = ST_FULL;
					end else begin
						best = 0;
						bd = dist_sq(node_x[0], node_y[0], px, py);
						for (int i = 1; i < node_count; i++) begin
							d = dist_sq(node_x[i], node_y[i], px, py);
							if (d < bd) begin
								bd = d;
								best = i;
							end
						end
						s = int'(step_len);
						dx = int'(px) - int'(node_x[best]);
						dy = int'(py) - int'(node_y[best]);
						if (bd == 0) begin
							// sample on the node: step along +x
							ox = s;
							oy = 0;
						end else begin
							ox = step_share(s, (dx < 0) ? -dx : dx, bd);
							oy = step_share(s, (dy < 0) ? -dy : dy, bd);
							if (dx < 0) ox = -ox;
							if (dy < 0) oy = -oy;
						end
						nx = clamp16(int'(node_x[best]) + ox);
						ny = clamp16(int'(node_y[best]) + oy);
						nchk = (obs_count < CIRCLE_CAP) ? int'(obs_count) : CIRCLE_CAP;
						hit = 0;
						for (int i = 0; i < nchk && !hit; i++)
							if (dist_sq(circ_x[i], circ_y[i], nx, ny) <=
									longint'(circ_r[i]) * longint'(circ_r[i]))
								hit = 1;
						r.node_x = nx[15:0];
						r.node_y = ny[15:0];
						r.parent_index = best[9:0];
						r.has_parent = 1'b1;
						if (hit) begin
							r.status = ST_COLLIDED;
						end else begin
							node_x[node_count] = nx[15:0];
							node_y[node_count] = ny[15:0];
							node_par[node_count] = best[9:0];
							r.node_index = node_count[9:0];
							node_count++;
							r.status = ST_ADDED;
							r.goal_reached = dist_sq(nx, ny, goal_x, goal_y) <=
								longint'(s) * longint'(s);
						end
					end
				end
				default: begin
					if (int'(idx) < node_count) begin
						r.status = ST_READ;
						r.node_index = idx;
						r.node_x = node_x[idx];
						r.node_y = node_y[idx];
						r.parent_index = (idx != 0) ? node_par[idx] : '0;
						r.has_parent = (idx != 0);
					end else begin
						r.status = ST_INVALID;
					end
				end
			endcase
			pending_q = {pending_q, r};
		endfunction

		task report_mismatch(string what);
			errors++;
			$display("[%0t] mismatch: %s", $realtime, what);
		endtask

		task check_beat(res_t got);
			res_t want;
			if (pending_q.size() == 0) begin
				report_mismatch("result beat with nothing expected");
			end else begin
				want = pending_q.pop_front();
				if (got.status != want.status)
					report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
				if (got.node_index != want.node_index)
					report_mismatch($sformatf("node_index %0d, want %0d",
						got.node_index, want.node_index));
				if (got.node_x != want.node_x)
					report_mismatch($sformatf("node_x %0d, want %0d",
						$signed(got.node_x), $signed(want.node_x)));
				if (got.node_y != want.node_y)
					report_mismatch($sformatf("node_y %0d, want %0d",
						$signed(got.node_y), $signed(want.node_y)));
				if (got.parent_index != want.parent_index)
					report_mismatch($sformatf("parent_index %0d, want %0d",
						got.parent_index, want.parent_index));
				if (got.has_parent != want.has_parent)
					report_mismatch($sformatf("has_parent %0b, want %0b",
						got.has_parent, want.has_parent));
				if (got.goal_reached != want.goal_reached)
					report_mismatch($sformatf("goal_reached %0b, want %0b",
						got.goal_reached, want.goal_reached));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [63:0] s_tdata;   // [15:0] pos_x, [31:16] pos_y, [46:32] radius, [56:47] index
	logic [1:0] s_tuser;    // [1:0] command
	logic m_tvalid;
	logic m_tready;
	logic [55:0] m_tdata;   // [9:0] node_index, [25:10] node_x, [41:26] node_y,
	                        // [51:42] parent_index, [52] has_parent, [53] goal_reached
	logic [2:0] m_tuser;    // [2:0] status
	logic cfg_valid;
	logic cfg_ready;
	logic [2:0] cfg_index;
	logic [15:0] cfg_data;

	tree_scoreboard sb;
	bit no_gaps;   // set for stretches with no idling on either side

	rrt_tree_extend_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// All handshakes are sampled here, at the rising edge, before the block's
	// own registers move. The result check runs ahead of the new command.
	always @(posedge clk) begin
		res_t got;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.status = status_t'(m_tuser);
				got.node_index = m_tdata[9:0];
				got.node_x = m_tdata[25:10];
				got.node_y = m_tdata[41:26];
				got.parent_index = m_tdata[51:42];
				got.has_parent = m_tdata[52];
				got.goal_reached = m_tdata[53];
				sb.check_beat(got);
			end
			if (s_tvalid && s_tready)
				sb.note_cmd(op_t'(s_tuser), s_tdata[15:0], s_tdata[31:16],
					s_tdata[46:32], s_tdata[56:47]);
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_reg_t'(cfg_index), cfg_data);
		end
	end

	// Result side: a fresh stall per result beat, held until the beat goes.
	initial begin
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = no_gaps ? 0 : $urandom_range(0, 13);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	function automatic logic [15:0] near16(int c, int span);
		return 16'(tree_scoreboard::clamp16(c + int'($urandom_range(0, 2 * span)) - span));
	endfunction

	// Returns right after the accepting edge with tvalid still high, so a
	// back-to-back beat never drops it; any other activity lowers it first.
	task automatic send_cmd(op_t op, logic [15:0] px, logic [15:0] py,
			logic [14:0] rad, logic [9:0] idx);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 13);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {7'b0, idx, rad, py, px};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending_q.size() != 0) @(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_cfg(cfg_reg_t idx, logic [15:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic setup_tree(int sx, int sy, int gx, int gy, int step, int cnt);
		write_cfg(CFG_START_X, sx[15:0]);
		write_cfg(CFG_START_Y, sy[15:0]);
		write_cfg(CFG_GOAL_X, gx[15:0]);
		write_cfg(CFG_GOAL_Y, gy[15:0]);
		write_cfg(CFG_STEP, step[15:0]);
		write_cfg(CFG_OBS_COUNT, cnt[15:0]);
		send_cmd(OP_RESTART, '0, '0, '0, '0);
	endtask

	// Mostly extends near the root, with obstacles dropped among the nodes,
	// reads of live and dead nodes, and an occasional restart.
	task automatic grow_random(int n, int cx, int cy, int cnt);
		int pick, span;
		logic [9:0] slot;
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(0, 99);
			span = $urandom_range(0, 3) == 0 ? 200 : 4000;
			if (pick < 5) begin
				send_cmd(OP_RESTART, 16'($urandom), 16'($urandom), 15'($urandom), 10'($urandom));
			end else if (pick < 25) begin
				slot = (cnt > 0 && $urandom_range(0, 3) != 0) ?
					10'($urandom_range(0, (cnt > 1024 ? 1024 : cnt) - 1)) : 10'($urandom);
				send_cmd(OP_OBSTACLE, near16(cx, 3000), near16(cy, 3000),
					$urandom_range(0, 9) == 0 ? 15'($urandom) : 15'($urandom_range(0, 400)),
					slot);
			end else if (pick < 78) begin
				if ($urandom_range(0, 6) == 0)
					send_cmd(OP_EXTEND, 16'($urandom), 16'($urandom), 15'($urandom),
						10'($urandom));
				else
					send_cmd(OP_EXTEND, near16(cx, span), near16(cy, span), 15'($urandom),
						10'($urandom));
			end else begin
				slot = $urandom_range(0, 4) == 0 ? 10'($urandom) :
					10'($urandom_range(0, sb.node_count + 2));
				send_cmd(OP_READ, 16'($urandom), 16'($urandom), 15'($urandom), slot);
			end
		end
	endtask

	initial begin
		int sx, sy;
		sb = new();
		no_gaps = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = OP_RESTART;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_START_X;
		cfg_data = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// directed, reset registers: root at 5.0, goal 9.0, step 26, no obstacles
		send_cmd(OP_READ, '0, '0, '0, 10'd0);
		send_cmd(OP_READ, '0, '0, '0, 10'd5);               // past the tree
		send_cmd(OP_EXTEND, 16'd1280, 16'd1280, '0, '0);     // sample on root
		send_cmd(OP_EXTEND, 16'd1293, 16'd5000, '0, '0);     // tie, lower index wins
		send_cmd(OP_EXTEND, 16'd2304, 16'd2304, '0, '0);
		send_cmd(OP_EXTEND, 16'h8000, 16'h8000, '0, '0);
		send_cmd(OP_EXTEND, 16'h7fff, 16'h7fff, '0, '0);
		send_cmd(OP_EXTEND, 16'h7fff, 16'h8000, '0, '0);
		send_cmd(OP_READ, '0, '0, '0, 10'd1);
		send_cmd(OP_READ, '0, '0, '0, 10'd3);
		send_cmd(OP_READ, '0, '0, '0, 10'd1023);
		send_cmd(OP_OBSTACLE, 16'd1280, 16'd1356, 15'd50, 10'd0);
		send_cmd(OP_OBSTACLE, 16'h8000, 16'h7fff, 15'h7fff, 10'd1023);
		send_cmd(OP_OBSTACLE, 16'h7fff, 16'h8000, 15'd0, 10'd1);
		send_cmd(OP_RESTART, '0, '0, '0, '0);
		write_cfg(CFG_OBS_COUNT, 16'd2);
		send_cmd(OP_EXTEND, 16'd1280, 16'd9000, '0, '0);     // lands on a circle edge
		send_cmd(OP_EXTEND, 16'd1280, 16'd0, '0, '0);
		send_cmd(OP_OBSTACLE, 16'd0, 16'd0, 15'h7fff, 10'd1);
		send_cmd(OP_EXTEND, 16'd3000, 16'd3000, '0, '0);     // inside the big circle
		send_cmd(OP_READ, '0, '0, '0, 10'd2);

		// park the low circle slots far away; obstacle counts stay within them
		no_gaps = 1'b1;
		for (int i = 0; i < CIRCLE_LIVE; i++)
			send_cmd(OP_OBSTACLE, 16'h8000, 16'h8000, 15'd0, 10'(i));
		no_gaps = 1'b0;

		// register extremes: saturating corners, largest and smallest steps,
		// zero step
		setup_tree(32767, -32768, 32767, -32000, 32767, CIRCLE_LIVE);
		grow_random(30, 32767, -32768, CIRCLE_LIVE);
		setup_tree(-32768, 32767, -32760, 32767, 1, 20);
		grow_random(30, -32768, 32767, 20);
		setup_tree(100, -100, 100, -100, 0, 5);
		grow_random(20, 100, -100, 5);
		no_gaps = 1'b1;
		setup_tree(0, 0, 300, 0, 600, 0);
		grow_random(20, 0, 0, 0);
		no_gaps = 1'b0;
		for (int p = 0; p < 4; p++) begin
			sx = int'($urandom_range(0, 40000)) - 20000;
			sy = int'($urandom_range(0, 40000)) - 20000;
			setup_tree(sx, sy, sx + int'($urandom_range(0, 1000)), sy - 300,
				$urandom_range(1, 2000), $urandom_range(0, 30));
			grow_random(28, sx, sy, int'(sb.obs_count));
		end

		// a few last extends and reads, live and dead
		send_cmd(OP_EXTEND, 16'd0, 16'd0, '0, '0);
		send_cmd(OP_READ, '0, '0, '0, 10'd1023);
		send_cmd(OP_EXTEND, 16'h8000, 16'h7fff, '0, '0);
		send_cmd(OP_READ, '0, '0, '0, 10'd0);

		drain();
		repeat (20) @(negedge clk);
		if (sb.errors == 0 && sb.pending_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#40ms;
		$display("== FAIL ==");
		$finish;
	end

endmodule
